[sv/mmms_pkg.sv]
package mmms_pkg;

   // Widths of the item fields on the ports.
   localparam int MARK_W      = 7;
   localparam int REQ_DATA_W  = 8;
   localparam int MODE_VAL_W  = 7;
   localparam int MODE_CNT_W  = 6;
   localparam int MEAN_W      = 15;
   localparam int MEDIAN_W    = 8;
   localparam int RSP_FIELD_W = MODE_VAL_W + MODE_CNT_W + MEAN_W + MEDIAN_W;
   localparam int RSP_DATA_W  = 40;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // Fraction bits of the mean.
   localparam int MEAN_FRAC_W = 8;

   // Result kinds carried on tuser.
   localparam logic KIND_MODE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_wr;     // write zero at the scan address and step it
      logic cap_mark;   // capture the incoming mark and read its bin
      logic inc;        // bump the bin, the count and the sum
      logic addr_rst;   // rewind the scan address
      logic trk_rst;    // reset the maximum and median trackers
      logic scan_rd;    // read the bin at the scan address and step it
      logic max_upd;    // fold the returned bin into the maximum
      logic med_upd;    // fold the returned bin into the median walk, clear it
      logic mode_emit;  // load a mode item into the output register
      logic sum_emit;   // load the summary item and clear count and sum
      logic div_start;  // start the mean division
   } mmms_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;  // scan address is at the top bin
      logic rd_last;    // returned bin is the top bin
      logic is_final;   // captured mark closes the run
      logic mode_hit;   // returned bin holds the highest count
      logic rsp_free;   // output register can take an item this cycle
      logic div_done;   // mean quotient is ready
   } mmms_status_type;

endpackage

[sv/mmms_div.sv]
module mmms_div
   import mmms_pkg::*;
#(
   parameter int NUM_W = 22,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // of the top of quot_ff while quotient bits shift in at the bottom.
   always_comb begin
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      if (start) begin
         rem_in  = '0;
         quot_in = num;
         cnt_in  = CNT_W'(NUM_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
         quot_in = {quot_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = !run_ff;
   assign quot = quot_ff;

endmodule

[sv/mmms_ctrl.sv]
module mmms_ctrl
   import mmms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mmms_status_type st,
   output mmms_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_CLEAR = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_INC   = 11'b000_0000_0100,
      S_START = 11'b000_0000_1000,
      S_MAXS  = 11'b000_0001_0000,
      S_MAXT  = 11'b000_0010_0000,
      S_MRD   = 11'b000_0100_0000,
      S_MCHK  = 11'b000_1000_0000,
      S_MEDS  = 11'b001_0000_0000,
      S_MEDT  = 11'b010_0000_0000,
      S_SUMW  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.scan_last) begin
               cmd.addr_rst = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap_mark = 1'b1;
               state_in     = S_INC;
            end
         end
         S_INC: begin
            cmd.inc  = 1'b1;
            state_in = st.is_final ? S_START : S_IDLE;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            cmd.addr_rst  = 1'b1;
            cmd.trk_rst   = 1'b1;
            state_in      = S_MAXS;
         end
         S_MAXS: begin
            cmd.scan_rd = 1'b1;
            cmd.max_upd = 1'b1;
            if (st.scan_last) begin
               state_in = S_MAXT;
            end
         end
         S_MAXT: begin
            cmd.max_upd  = 1'b1;
            cmd.addr_rst = 1'b1;
            state_in     = S_MRD;
         end
         S_MRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_MCHK;
         end
         S_MCHK: begin
            // A bin at the highest count waits here until the output register frees.
            if (!st.mode_hit || st.rsp_free) begin
               cmd.mode_emit = st.mode_hit;
               if (st.rd_last) begin
                  cmd.addr_rst = 1'b1;
                  state_in     = S_MEDS;
               end else begin
                  state_in = S_MRD;
               end
            end
         end
         S_MEDS: begin
            cmd.scan_rd = 1'b1;
            cmd.med_upd = 1'b1;
            if (st.scan_last) begin
               state_in = S_MEDT;
            end
         end
         S_MEDT: begin
            cmd.med_upd = 1'b1;
            state_in    = S_SUMW;
         end
         S_SUMW: begin
            if (st.div_done && st.rsp_free) begin
               cmd.sum_emit = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/mmms_dp.sv]
module mmms_dp
   import mmms_pkg::*;
#(
   parameter int MAX_ITEMS = 32,
   parameter int TOP_SCORE = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mmms_cmd_type          cmd,
   output mmms_status_type       st,
   input  logic [MARK_W-1:0]     req_mark,
   input  logic                  req_final,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [RSP_DATA_W-1:0] rsp_data,
   output logic                  rsp_last
);

   localparam int AW = $clog2(TOP_SCORE + 1);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int SW = $clog2(MAX_ITEMS * TOP_SCORE + 1);
   localparam int DW = SW + MEAN_FRAC_W;

   // Histogram: one count per score bin.
   logic [CW-1:0] hist_mem [0:TOP_SCORE];

   logic [AW-1:0] rd_addr, wr_addr;
   logic [CW-1:0] wr_data;
   logic          rd_en, wr_en;
   logic [CW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          rdv_ff;

   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0] mark_ff;
   logic          final_ff;
   logic [7:0]    mark8, top8, clip8;
   logic [AW-1:0] clip;

   logic [CW-1:0] count_ff, count_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          room;

   logic [CW-1:0] max_ff, max_in;
   logic [CW-1:0] cum_ff, cum_in, cum_next;
   logic [AW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic          lo_found_ff, lo_found_in, hi_found_ff, hi_found_in;
   logic [CW-1:0] k_lo, k_hi;

   logic          div_done;
   logic [DW-1:0] quot;
   logic [MEAN_W-1:0]     mean;
   logic [8:0]            med9;
   logic [7:0]            val8;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_free;

   // Marks above the top score count in the top bin.
   assign mark8 = {1'b0, req_mark};
   assign top8  = 8'(TOP_SCORE);
   assign clip8 = (mark8 > top8) ? top8 : mark8;
   assign clip  = clip8[AW-1:0];

   assign room = count_ff < CW'(MAX_ITEMS);

   // Memory port selection; the controller never asks for two writes at once.
   always_comb begin
      rd_en   = cmd.cap_mark || cmd.scan_rd;
      rd_addr = cmd.cap_mark ? clip : scan_addr_ff;
      wr_en   = 1'b0;
      wr_addr = scan_addr_ff;
      wr_data = '0;
      if (cmd.inc && room) begin
         wr_en   = 1'b1;
         wr_addr = mark_ff;
         wr_data = rd_data_ff + CW'(1);
      end else if (cmd.clr_wr) begin
         wr_en = 1'b1;
      end else if (cmd.med_upd && rdv_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.addr_rst) begin
         scan_addr_in = '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
         scan_addr_in = scan_addr_ff + AW'(1);
      end
   end

   // Run totals.
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.sum_emit) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.inc && room) begin
         count_in = count_ff + CW'(1);
         sum_in   = sum_ff + SW'(mark_ff);
      end
   end

   // Highest count, then the cumulative walk that finds the two middle marks.
   assign k_lo     = (count_ff - CW'(1)) >> 1;
   assign k_hi     = count_ff >> 1;
   assign cum_next = cum_ff + rd_data_ff;

   always_comb begin
      max_in      = max_ff;
      cum_in      = cum_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      lo_found_in = lo_found_ff;
      hi_found_in = hi_found_ff;
      if (cmd.trk_rst) begin
         max_in      = '0;
         cum_in      = '0;
         lo_in       = AW'(TOP_SCORE);
         hi_in       = AW'(TOP_SCORE);
         lo_found_in = 1'b0;
         hi_found_in = 1'b0;
      end else begin
         if (cmd.max_upd && rdv_ff && (rd_data_ff > max_ff)) begin
            max_in = rd_data_ff;
         end
         if (cmd.med_upd && rdv_ff) begin
            cum_in = cum_next;
            if (!lo_found_ff && (cum_next > k_lo)) begin
               lo_in       = rd_addr_ff;
               lo_found_in = 1'b1;
            end
            if (!hi_found_ff && (cum_next > k_hi)) begin
               hi_in       = rd_addr_ff;
               hi_found_in = 1'b1;
            end
         end
      end
   end

   mmms_div #(
      .NUM_W (DW),
      .DEN_W (CW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({sum_ff, MEAN_FRAC_W'(0)}),
      .den   (count_ff),
      .done  (div_done),
      .quot  (quot)
   );

   assign mean = (count_ff == '0) ? '0 : MEAN_W'(quot);
   assign med9 = 9'(lo_ff) + 9'(hi_ff);
   assign val8 = 8'(rd_addr_ff);

   // Output register.
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.mode_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_MODE;
         rsp_last_in  = 1'b0;
         rsp_data_in  = {RSP_PAD_W'(0), MEDIAN_W'(0), MEAN_W'(0),
                         MODE_CNT_W'(max_ff), val8[MODE_VAL_W-1:0]};
      end else if (cmd.sum_emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_SUMMARY;
         rsp_last_in  = 1'b1;
         rsp_data_in  = {RSP_PAD_W'(0), med9[MEDIAN_W-1:0], mean,
                         MODE_CNT_W'(0), MODE_VAL_W'(0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         rdv_ff       <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_addr_ff <= scan_addr_in;
         rdv_ff       <= cmd.scan_rd;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.scan_rd) begin
         rd_addr_ff <= scan_addr_ff;
      end
      if (cmd.cap_mark) begin
         mark_ff  <= clip;
         final_ff <= req_final;
      end
      max_ff      <= max_in;
      cum_ff      <= cum_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      lo_found_ff <= lo_found_in;
      hi_found_ff <= hi_found_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign st.scan_last = scan_addr_ff == AW'(TOP_SCORE);
   assign st.rd_last   = rd_addr_ff == AW'(TOP_SCORE);
   assign st.is_final  = final_ff;
   assign st.mode_hit  = (rd_data_ff == max_ff) && (max_ff != '0);
   assign st.rsp_free  = rsp_free;
   assign st.div_done  = div_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

[sv/mode_mean_median_stats_unit.sv]
// Score statistics over a run of marks. Marks arrive one item at a time on the req
// channel, the last mark of a run flagged by req_tlast; marks above TOP_SCORE count as
// TOP_SCORE, and marks beyond MAX_ITEMS in one run are dropped (a dropped final mark
// still ends the run). Each mark is counted in a histogram held in a single-port-write,
// registered-read memory, so each mark is a read-modify-write: its bin is read as the
// mark is captured and written back in the increment state. After the final mark the
// controller makes three passes over the TOP_SCORE+1 bins: a pass that finds the
// highest count, a pass that reads and checks each bin in ascending score order and
// sends one mode item for every bin at that count, waiting while the rsp side stalls,
// and a cumulative walk that picks the two middle marks and clears every bin behind
// it. The summary item then follows with the floored mean in Q8 from a bit-serial
// divider that runs during the passes, and twice the median; it carries rsp_tlast. No
// mark is taken while the passes run. After reset the histogram is cleared by a pass
// over every bin, during which req_tready stays low.
module mode_mean_median_stats_unit
   import mmms_pkg::*;
#(
   parameter int MAX_ITEMS = 32,
   parameter int TOP_SCORE = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [6:0] mark, [7] zero
   input  logic                  req_tlast,   // final_mark
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [6:0] mode_value, [12:7] mode_count,
                                              // [27:13] mean_q8, [35:28] median_x2,
                                              // [39:36] zero
   output logic                  rsp_tuser,   // kind
   output logic                  rsp_tlast    // end_of_run
);

   mmms_cmd_type    cmd;
   mmms_status_type st;

   // The controller sequences mark capture, histogram update and the end-of-run passes.
   mmms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath holds the histogram, the run totals, the trackers and the
   // output register.
   mmms_dp #(
      .MAX_ITEMS (MAX_ITEMS),
      .TOP_SCORE (TOP_SCORE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_mark  (req_tdata[MARK_W-1:0]),
      .req_final (req_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // The histogram update needs its own state after the capture, so an accepted mark always
   // closes the input for the following cycle.
   a_ready_gap: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("mark accepted during histogram update");

   // Only the summary item closes a run.
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == rsp_tuser))
      else $error("end of run flag and kind disagree");

   // A mode item always reports a nonzero count.
   a_mode_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_MODE)) |-> (rsp_tdata[12:7] != '0))
      else $error("mode item with zero count");
`endif

endmodule
